// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the allocator top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int ADDR_W   = 32;
    localparam int LIMIT_W  = 21;
    localparam int STATUS_W = 3;
    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 21'd1024;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_RESIZE = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NULL         = 3'd1,
        ST_NO_PAGES     = 3'd2,
        ST_TABLE_FULL   = 3'd3,
        ST_UNKNOWN      = 3'd4,
        ST_DOUBLE_FREE  = 3'd5,
        ST_RESIZE_FREED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_HIT  = 2'd1,
        RES_NEW  = 2'd2,
        RES_IN   = 2'd3
    } t_res_sel;

    typedef enum logic {
        SCAN_FIT  = 1'b0,
        SCAN_ADDR = 1'b1
    } t_scan_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_FIT,
        S_BUMP_BASE,
        S_BUMP_END,
        S_BUMP_PAGES,
        S_BUMP_COMMIT,
        S_OLD_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        t_scan_mode scan_mode;
        logic       bump_end;
        logic       bump_pages;
        logic       bump_commit;
        logic       wr_hit_used;
        logic       wr_hit_free;
        logic       wr_old_free;
        logic       save_old;
        logic       rsp_set;
        t_status    rsp_status;
        t_res_sel   rsp_res;
        logic       rsp_copy;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       addr_zero;
        logic       size_zero;
        logic       scan_done;
        logic       scan_hit;
        logic       hit_free;
        logic       hit_fits;
        logic       table_full;
        logic       end_ovf;
        logic       pages_short;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/ffba_in_if.sv =====
`timescale 1ns / 1ps
interface ffba_in_if import ffba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] request_size;

    modport source (output valid, func, block_address, request_size, input ready);
    modport sink (input valid, func, block_address, request_size, output ready);
endinterface

// ===== rtl/ffba_out_if.sv =====
`timescale 1ns / 1ps
interface ffba_out_if import ffba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
    logic [ADDR_W-1:0]   copy_from;
    logic [ADDR_W-1:0]   copy_length;

    modport source (output valid, status, result_address, copy_from, copy_length,
                    input ready);
    modport sink (input valid, status, result_address, copy_from, copy_length,
                  output ready);
endinterface

// ===== rtl/ffba_ram.sv =====
`timescale 1ns / 1ps
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ffba_ctrl.sv =====
`timescale 1ns / 1ps
module ffba_ctrl import ffba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_grow, n_grow;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grow  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_grow  <= n_grow;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_grow     = r_grow;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_grow     = 1'b0;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                o_cmd.rsp_set    = 1'b1;
                o_cmd.rsp_status = ST_OK;
                o_cmd.rsp_res    = RES_NONE;
                case (i_sts.func)
                    FUNC_ALLOC: begin
                        if (i_sts.size_zero) begin
                            o_cmd.rsp_status = ST_NULL;
                        end else begin
                            o_cmd.rsp_set    = 1'b0;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_mode  = SCAN_FIT;
                            n_state          = S_FIT;
                        end
                    end
                    FUNC_FREE: begin
                        if (!i_sts.addr_zero) begin
                            o_cmd.rsp_set    = 1'b0;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_mode  = SCAN_ADDR;
                            n_state          = S_FIND;
                        end
                    end
                    FUNC_RESIZE: begin
                        if (i_sts.addr_zero && i_sts.size_zero) begin
                            o_cmd.rsp_status = ST_NULL;
                        end else if (i_sts.addr_zero) begin
                            o_cmd.rsp_set    = 1'b0;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_mode  = SCAN_FIT;
                            n_state          = S_FIT;
                        end else begin
                            o_cmd.rsp_set    = 1'b0;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_mode  = SCAN_ADDR;
                            n_state          = S_FIND;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIND: begin
                if (i_sts.scan_done) begin
                    o_cmd.rsp_set = 1'b1;
                    o_cmd.rsp_res = RES_NONE;
                    n_state       = S_DONE;
                    if (!i_sts.scan_hit) begin
                        o_cmd.rsp_status = ST_UNKNOWN;
                    end else if (i_sts.func == FUNC_FREE || i_sts.size_zero) begin
                        // plain free, or resize to zero
                        if (i_sts.hit_free) begin
                            o_cmd.rsp_status = ST_DOUBLE_FREE;
                        end else begin
                            o_cmd.wr_hit_free = 1'b1;
                            o_cmd.rsp_status  = (i_sts.func == FUNC_FREE) ? ST_OK : ST_NULL;
                        end
                    end else if (i_sts.hit_free) begin
                        o_cmd.rsp_status = ST_RESIZE_FREED;
                    end else if (i_sts.hit_fits) begin
                        o_cmd.rsp_status = ST_OK;
                        o_cmd.rsp_res    = RES_IN;
                    end else begin
                        // grow: keep old entry, allocate a new one
                        o_cmd.rsp_set    = 1'b0;
                        o_cmd.save_old   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_mode  = SCAN_FIT;
                        n_grow           = 1'b1;
                        n_state          = S_FIT;
                    end
                end
            end
            S_FIT: begin
                if (i_sts.scan_done) begin
                    o_cmd.rsp_set = 1'b1;
                    if (i_sts.scan_hit) begin
                        o_cmd.wr_hit_used = 1'b1;
                        o_cmd.rsp_status  = ST_OK;
                        o_cmd.rsp_res     = RES_HIT;
                        o_cmd.rsp_copy    = r_grow;
                        n_state           = r_grow ? S_OLD_FREE : S_DONE;
                    end else if (i_sts.table_full) begin
                        o_cmd.rsp_status = ST_TABLE_FULL;
                        o_cmd.rsp_res    = RES_NONE;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.rsp_set = 1'b0;
                        n_state       = S_BUMP_BASE;
                    end
                end
            end
            S_BUMP_BASE: begin
                o_cmd.bump_end = 1'b1;
                n_state        = S_BUMP_END;
            end
            S_BUMP_END: begin
                o_cmd.bump_pages = 1'b1;
                n_state          = S_BUMP_PAGES;
            end
            S_BUMP_PAGES: begin
                n_state = S_BUMP_COMMIT;
            end
            S_BUMP_COMMIT: begin
                o_cmd.rsp_set = 1'b1;
                n_state       = S_DONE;
                if (i_sts.end_ovf) begin
                    o_cmd.rsp_status = ST_NO_PAGES;
                end else begin
                    o_cmd.bump_commit = 1'b1;
                    if (i_sts.pages_short) begin
                        o_cmd.rsp_status = ST_NO_PAGES;
                    end else begin
                        o_cmd.rsp_status = ST_OK;
                        o_cmd.rsp_res    = RES_NEW;
                        o_cmd.rsp_copy   = r_grow;
                        n_state          = r_grow ? S_OLD_FREE : S_DONE;
                    end
                end
            end
            S_OLD_FREE: begin
                o_cmd.wr_old_free = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/ffba_dp.sv =====
`timescale 1ns / 1ps
module ffba_dp import ffba_pkg::*; #(
    parameter int MAX_BLOCKS    = 64,
    parameter int HEADER_BYTES  = 32,
    parameter int ALIGN_BYTES   = 64,
    parameter int PAGE_BYTES    = 4096,
    parameter int INITIAL_PAGES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    ffba_in_if.sink            i_req,
    ffba_out_if.source         o_rsp,
    input  t_cmd               i_cmd,
    output t_sts               o_sts
);
    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int EW  = 2 * ADDR_W + 1;
    localparam int PS  = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0]     MAX_CNT  = CW'(MAX_BLOCKS);
    localparam logic [ADDR_W:0]   HDR      = (ADDR_W+1)'(HEADER_BYTES);
    localparam logic [ADDR_W:0]   ALIGN_M1 = (ADDR_W+1)'(ALIGN_BYTES - 1);
    localparam logic [ADDR_W-1:0] MAP_RST  = ADDR_W'(INITIAL_PAGES * PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PAGE_CAP = {ADDR_W{1'b1}} >> PS;

    // captured item and heap state
    logic [1:0]         r_func;
    logic [ADDR_W-1:0]  r_addr, r_size;
    logic [CW-1:0]      r_count;
    logic [ADDR_W-1:0]  r_bump, r_mapped;
    logic [LIMIT_W-1:0] r_page_limit;

    // scan state
    logic               r_scan_on, r_scan_done, r_scan_hit, r_pend;
    t_scan_mode         r_scan_mode;
    logic [CW-1:0]      r_scan_idx;
    logic [AW-1:0]      r_pend_idx, r_hit_idx, r_old_idx;
    logic [ADDR_W-1:0]  r_hit_base, r_hit_size, r_old_base, r_old_size;
    logic               r_hit_free;

    // bump pipeline
    logic [ADDR_W:0]    r_base;
    logic [ADDR_W+1:0]  r_end;
    logic               r_map_needed;
    logic [ADDR_W-1:0]  r_need, r_avail;

    // pending result and output register
    t_status            r_rsp_status;
    t_res_sel           r_rsp_res;
    logic               r_rsp_copy;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDR_W-1:0]  r_out_res, r_out_from, r_out_len;

    logic               issue, match, pages_short;
    logic [EW-1:0]      rd_data, wr_data;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_base, rd_size, limit, have, diff, res_val;
    logic [ADDR_W:0]    base_next;
    logic [ADDR_W-1:0]  map_add;

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_base = rd_data[ADDR_W-1:0];
    assign rd_size = rd_data[2*ADDR_W-1:ADDR_W];

    // compare the entry read in the previous cycle
    always_comb begin
        if (r_scan_mode == SCAN_FIT) begin
            match = rd_data[EW-1] && (rd_size >= r_size);
        end else begin
            match = ({1'b0, rd_base} + HDR) == {1'b0, r_addr};
        end
    end
    assign issue = r_scan_on && (r_scan_idx < r_count) && !(r_pend && match);

    // page math on the registered bump stage
    assign pages_short = r_map_needed && (r_need > r_avail);
    assign map_add     = pages_short ? r_avail : r_need;
    assign base_next   = ({1'b0, r_bump} + ALIGN_M1) & ~ALIGN_M1;
    assign diff        = r_end[ADDR_W-1:0] - r_mapped;
    assign limit       = ({{(ADDR_W-LIMIT_W){1'b0}}, r_page_limit} > PAGE_CAP) ? PAGE_CAP
                         : {{(ADDR_W-LIMIT_W){1'b0}}, r_page_limit};
    assign have        = r_mapped >> PS;

    // table write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit_idx;
        wr_data = {1'b0, r_hit_size, r_hit_base};
        if (i_cmd.wr_hit_used || i_cmd.wr_hit_free) begin
            wr_en   = 1'b1;
            wr_data = {i_cmd.wr_hit_free, r_hit_size, r_hit_base};
        end else if (i_cmd.bump_commit && !pages_short) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = {1'b0, r_size, r_base[ADDR_W-1:0]};
        end else if (i_cmd.wr_old_free) begin
            wr_en   = 1'b1;
            wr_addr = r_old_idx;
            wr_data = {1'b1, r_old_size, r_old_base};
        end
    end

    // control state: counts, scan and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_bump       <= '0;
            r_mapped     <= MAP_RST;
            r_page_limit <= PAGE_LIMIT_RST;
            r_scan_on    <= 1'b0;
            r_scan_done  <= 1'b0;
            r_scan_hit   <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_page_limit <= i_cfg_wdata;
            end
            if (i_cmd.bump_commit) begin
                r_bump   <= r_end[ADDR_W-1:0];
                if (r_map_needed) begin
                    r_mapped <= r_mapped + (map_add << PS);
                end
                if (!pages_short) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_scan_on   <= 1'b1;
                r_scan_done <= 1'b0;
                r_scan_hit  <= 1'b0;
                r_pend      <= 1'b0;
            end else begin
                r_pend <= issue;
                if (r_scan_on && r_pend && match) begin
                    r_scan_on   <= 1'b0;
                    r_scan_done <= 1'b1;
                    r_scan_hit  <= 1'b1;
                end else if (r_scan_on && !r_pend && !(r_scan_idx < r_count)) begin
                    r_scan_on   <= 1'b0;
                    r_scan_done <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_addr <= i_req.block_address;
            r_size <= i_req.request_size;
        end
        if (i_cmd.scan_start) begin
            r_scan_mode <= i_cmd.scan_mode;
            r_scan_idx  <= '0;
        end else if (issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        r_pend_idx <= r_scan_idx[AW-1:0];
        if (r_scan_on && r_pend && match) begin
            r_hit_idx  <= r_pend_idx;
            r_hit_base <= rd_base;
            r_hit_size <= rd_size;
            r_hit_free <= rd_data[EW-1];
        end
        if (i_cmd.save_old) begin
            r_old_idx  <= r_hit_idx;
            r_old_base <= r_hit_base;
            r_old_size <= r_hit_size;
        end
        // hold the aligned base for the whole item; the bump offset moves at commit
        if (i_cmd.scan_start) begin
            r_base <= base_next;
        end
        if (i_cmd.bump_end) begin
            r_end <= {1'b0, r_base} + {1'b0, HDR} + {2'b00, r_size};
        end
        if (i_cmd.bump_pages) begin
            r_map_needed <= ({2'b00, r_mapped} <= r_end);
            r_need       <= (diff >> PS) + 1'b1;
            r_avail      <= (limit > have) ? (limit - have) : '0;
        end
        if (i_cmd.rsp_set) begin
            r_rsp_status <= i_cmd.rsp_status;
            r_rsp_res    <= i_cmd.rsp_res;
            r_rsp_copy   <= i_cmd.rsp_copy;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_rsp_status;
            r_out_res    <= res_val;
            r_out_from   <= r_rsp_copy ? r_addr : '0;
            r_out_len    <= r_rsp_copy ? r_old_size : '0;
        end
    end

    // pick the returned pointer
    always_comb begin
        unique case (r_rsp_res)
            RES_HIT:  res_val = r_hit_base + HDR[ADDR_W-1:0];
            RES_NEW:  res_val = r_base[ADDR_W-1:0] + HDR[ADDR_W-1:0];
            RES_IN:   res_val = r_addr;
            default:  res_val = '0;
        endcase
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.result_address = r_out_res;
    assign o_rsp.copy_from      = r_out_from;
    assign o_rsp.copy_length    = r_out_len;

    assign o_sts.func        = r_func;
    assign o_sts.addr_zero   = (r_addr == '0);
    assign o_sts.size_zero   = (r_size == '0);
    assign o_sts.scan_done   = r_scan_done;
    assign o_sts.scan_hit    = r_scan_hit;
    assign o_sts.hit_free    = r_hit_free;
    assign o_sts.hit_fits    = (r_hit_size >= r_size);
    assign o_sts.table_full  = (r_count >= MAX_CNT);
    assign o_sts.end_ovf     = (r_end[ADDR_W+1:ADDR_W] != 2'b00);
    assign o_sts.pages_short = pages_short;
    assign o_sts.out_free    = !r_out_valid || o_rsp.ready;
endmodule

// ===== rtl/first_fit_bump_heap_allocator_unit.sv =====
// The time from accept to result valid is set mostly by the table walk (one entry read per cycle
// from the block table RAM, up to twice per item).
// Throughput: one item at a time; the next item is taken once the result is in
// the output register, which holds it until the sink takes it.
// Reset: synchronous, active low; empties the table, clears the bump offset and
// maps the initial pages. Table entries need no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_bump_heap_allocator_unit import ffba_pkg::*; #(
    parameter int MAX_BLOCKS    = 64,
    parameter int HEADER_BYTES  = 32,
    parameter int ALIGN_BYTES   = 64,
    parameter int PAGE_BYTES    = 4096,
    parameter int INITIAL_PAGES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    ffba_in_if.sink            i_req,
    ffba_out_if.source         o_rsp
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffba_dp #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .HEADER_BYTES  (HEADER_BYTES),
        .ALIGN_BYTES   (ALIGN_BYTES),
        .PAGE_BYTES    (PAGE_BYTES),
        .INITIAL_PAGES (INITIAL_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign i_req.ready = in_ready;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && in_ready, !in_ready, "accepted a second item while busy")
    `ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, cmd.out_load, sts.out_free, "result register overwritten")
    `ASSERT_SAME(a_commit_not_full, i_clk, i_rst_n, cmd.bump_commit, !sts.table_full, "new entry written into a full table")
endmodule

// ===== test/first_fit_bump_heap_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
module first_fit_bump_heap_allocator_unit_tb import ffba_pkg::*; ();

    localparam int NBLK     = 64;
    localparam int HDR      = 32;
    localparam int ALIGN    = 64;
    localparam int PAGE     = 4096;
    localparam int INIT_PG  = 4;
    localparam int LAT_MAX  = 2 * NBLK + 14;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [31:0] size;
    } t_req;

    typedef struct {
        t_status     status;
        logic [31:0] res;
        logic [31:0] cfrom;
        logic [31:0] clen;
    } t_rsp;

    // Directed row: the typed-in answer is used only when has_rsp is set
    typedef struct {
        t_req req;
        bit   has_rsp;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    ffba_in_if  req_if ();
    ffba_out_if rsp_if ();

    first_fit_bump_heap_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // Heap shadow
    logic [31:0] hp_base [NBLK];
    logic [31:0] hp_size [NBLK];
    bit          hp_free [NBLK];
    int          hp_count;
    logic [31:0] hp_bump;
    logic [31:0] hp_mapped;
    logic [20:0] hp_page_limit;

    t_rsp pending_rsp [$];
    int   n_errors;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("first_fit_bump_heap_allocator_unit_tb failed");
        $finish;
    end

    function automatic t_status heap_grab(input logic [31:0] size, output logic [31:0] addr);
        logic [63:0] base, end_off, need, lim, have, avail;
        addr = '0;
        if (size == 0) return ST_NULL;
        for (int i = 0; i < hp_count; i++) begin
            if (hp_free[i] && hp_size[i] >= size) begin
                hp_free[i] = 1'b0;
                addr = hp_base[i] + HDR;
                return ST_OK;
            end
        end
        if (hp_count >= NBLK) return ST_TABLE_FULL;
        base = ((64'(hp_bump) + ALIGN - 1) / ALIGN) * ALIGN;
        end_off = base + 64'(size) + HDR;
        if (end_off > 64'hFFFF_FFFF) return ST_NO_PAGES;
        hp_bump = end_off[31:0];
        if (64'(hp_mapped) <= end_off) begin
            need = (end_off - hp_mapped) / PAGE + 1;
            lim = 64'(hp_page_limit);
            if (lim > 64'hFFFF_FFFF / PAGE) lim = 64'hFFFF_FFFF / PAGE;
            have = 64'(hp_mapped) / PAGE;
            avail = (lim > have) ? lim - have : 0;
            if (need > avail) begin
                hp_mapped = hp_mapped + 32'(avail * PAGE);
                return ST_NO_PAGES;
            end
            hp_mapped = hp_mapped + 32'(need * PAGE);
        end
        hp_base[hp_count] = base[31:0];
        hp_size[hp_count] = size;
        hp_free[hp_count] = 1'b0;
        hp_count++;
        addr = base[31:0] + HDR;
        return ST_OK;
    endfunction

    function automatic int heap_lookup(input logic [31:0] addr);
        for (int i = 0; i < hp_count; i++)
            if (64'(hp_base[i]) + HDR == 64'(addr)) return i;
        return -1;
    endfunction

    function automatic t_status heap_release(input logic [31:0] addr);
        int k;
        if (addr == 0) return ST_OK;
        k = heap_lookup(addr);
        if (k < 0) return ST_UNKNOWN;
        if (hp_free[k]) return ST_DOUBLE_FREE;
        hp_free[k] = 1'b1;
        return ST_OK;
    endfunction

    function automatic t_rsp heap_predict(input t_req r);
        t_rsp o;
        int k;
        logic [31:0] old_size;
        o = '{ST_OK, 0, 0, 0};
        case (r.func)
            FUNC_ALLOC: o.status = heap_grab(r.size, o.res);
            FUNC_FREE:  o.status = heap_release(r.addr);
            FUNC_RESIZE: begin
                if (r.addr == 0 && r.size == 0) begin
                    o.status = ST_NULL;
                end else if (r.size == 0) begin
                    o.status = heap_release(r.addr);
                    if (o.status == ST_OK) o.status = ST_NULL;
                end else if (r.addr == 0) begin
                    o.status = heap_grab(r.size, o.res);
                end else begin
                    k = heap_lookup(r.addr);
                    if (k < 0) o.status = ST_UNKNOWN;
                    else if (hp_free[k]) o.status = ST_RESIZE_FREED;
                    else if (hp_size[k] >= r.size) o.res = r.addr;
                    else begin
                        old_size = hp_size[k];
                        o.status = heap_grab(r.size, o.res);
                        if (o.status == ST_OK) begin
                            o.cfrom = r.addr;
                            o.clen = old_size;
                            hp_free[k] = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // Send one item and queue what it should return
    task automatic send_item(input t_req r, input bit has_rsp, input t_rsp typed);
        t_rsp p;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= r.func;
        req_if.block_address <= r.addr;
        req_if.request_size <= r.size;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        p = heap_predict(r);
        pending_rsp.push_back(has_rsp ? typed : p);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge i_clk);
        repeat (LAT_MAX) @(negedge i_clk);
    endtask

    task automatic set_page_limit(input logic [20:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        hp_page_limit = v;
    endtask

    function automatic t_req rand_req();
        t_req r;
        int pick;
        pick = $urandom_range(99);
        r.func = (pick < 45) ? FUNC_ALLOC : (pick < 70) ? FUNC_FREE :
                 (pick < 97) ? FUNC_RESIZE : FUNC_UNUSED;
        case ($urandom_range(9))
            0: r.size = 0;
            1: r.size = $urandom();
            2: r.size = 32'hFFFF_FFFF - $urandom_range(200);
            3, 4: r.size = $urandom_range(20000);
            default: r.size = $urandom_range(600);
        endcase
        pick = $urandom_range(9);
        if (pick < 6 && hp_count > 0)
            r.addr = hp_base[$urandom_range(hp_count - 1)] + HDR;
        else if (pick < 7) r.addr = 0;
        else if (pick < 8) r.addr = $urandom();
        else r.addr = $urandom_range(40000);
        return r;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected item: status %0d", rsp_if.status);
                n_errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_if.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, rsp_if.status);
                    n_errors++;
                end
                if (rsp_if.result_address !== e.res) begin
                    $error("result_address: expected %h, got %h", e.res,
                           rsp_if.result_address);
                    n_errors++;
                end
                if (rsp_if.copy_from !== e.cfrom) begin
                    $error("copy_from: expected %h, got %h", e.cfrom, rsp_if.copy_from);
                    n_errors++;
                end
                if (rsp_if.copy_length !== e.clen) begin
                    $error("copy_length: expected %h, got %h", e.clen, rsp_if.copy_length);
                    n_errors++;
                end
            end
        end
    end

    // Sink ready: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        t_row rows [$];
        t_rsp none;
        none = '{ST_OK, 0, 0, 0};
        n_errors = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_ALLOC;
        req_if.block_address = '0;
        req_if.request_size = '0;
        rsp_if.ready = 1'b0;
        hp_count = 0;
        hp_bump = 0;
        hp_mapped = INIT_PG * PAGE;
        hp_page_limit = PAGE_LIMIT_RST;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: reset state, extremes and error codes
        rows = '{
            '{'{FUNC_ALLOC, 0, 0}, 1, '{ST_NULL, 0, 0, 0}},
            '{'{FUNC_ALLOC, 0, 100}, 1, '{ST_OK, 32, 0, 0}},
            '{'{FUNC_ALLOC, 0, 32'hFFFF_FFFF}, 1, '{ST_NO_PAGES, 0, 0, 0}},
            '{'{FUNC_FREE, 0, 0}, 1, none},
            '{'{FUNC_FREE, 32'hFFFF_FFFF, 0}, 1, '{ST_UNKNOWN, 0, 0, 0}},
            '{'{FUNC_FREE, 32, 0}, 1, none},
            '{'{FUNC_FREE, 32, 0}, 1, '{ST_DOUBLE_FREE, 0, 0, 0}},
            '{'{FUNC_RESIZE, 32, 50}, 1, '{ST_RESIZE_FREED, 0, 0, 0}},
            '{'{FUNC_RESIZE, 0, 0}, 1, '{ST_NULL, 0, 0, 0}},
            '{'{FUNC_ALLOC, 0, 80}, 1, '{ST_OK, 32, 0, 0}},
            '{'{FUNC_RESIZE, 32, 90}, 1, '{ST_OK, 32, 0, 0}},
            '{'{FUNC_RESIZE, 32, 5000}, 0, none},
            '{'{FUNC_RESIZE, 0, 300}, 0, none},
            '{'{FUNC_RESIZE, 7, 10}, 1, '{ST_UNKNOWN, 0, 0, 0}},
            '{'{FUNC_RESIZE, 32, 0}, 0, none},
            '{'{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, none},
            '{'{FUNC_ALLOC, 0, 1}, 0, none},
            '{'{FUNC_ALLOC, 0, 60000}, 0, none},
            '{'{FUNC_ALLOC, 0, 32'h0FFF_FFFF}, 0, none}
        };
        foreach (rows[i]) send_item(rows[i].req, rows[i].has_rsp, rows[i].rsp);
        drain();

        // Phases of idling and page limits; long receiver hold-off in the second phase
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  set_page_limit(21'd4); end
                1: begin src_idle_pct = 66; snk_stall_pct = 0;  set_page_limit(21'h1FFFFF); end
                2: begin src_idle_pct = 0;  snk_stall_pct = 66; set_page_limit(21'd40); end
                3: begin src_idle_pct = 31; snk_stall_pct = 31; set_page_limit(21'd1024); end
                default: begin src_idle_pct = 0; snk_stall_pct = 0;
                    set_page_limit(21'h100000); end
            endcase
            if (ph == 1) hold_off = 400;
            for (int n = 0; n < 72; n++) send_item(rand_req(), 0, none);
            drain();
        end

        // Fill the table with small blocks, then ask for more
        for (int n = 0; n < 70; n++)
            send_item('{FUNC_ALLOC, 0, 32'(5000 + n)}, 0, none);
        drain();

        if (n_errors == 0)
            $display("first_fit_bump_heap_allocator_unit_tb passed");
        else
            $display("first_fit_bump_heap_allocator_unit_tb failed");
        $finish;
    end

endmodule
